// ===== rtl/crc16x_pkg.sv =====
// Package for the CRC-16/X.25 generate/check block.
// Holds item types, queue sizing constants and the byte-wide CRC update.
// No dependencies.
package crc16x_pkg;

    localparam logic [15:0] CRC_PRESET   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY_REF = 16'h8408;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
        logic       check_mode;
    } in_item_t;

    typedef struct packed {
        logic [15:0] crc_value;
        logic        crc_ok;
        logic        too_short;
    } out_item_t;

    typedef struct packed {
        logic       valid;
        logic       ready;
    } q_hs_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY_REF;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/crc16x_front.sv =====
// Front end: accepts input items, tracks message framing and drops stray bytes.
// Depends on crc16x_pkg.
module crc16x_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  crc16x_pkg::in_item_t s_data,
    output crc16x_pkg::q_hs_t   push_hs,
    input  logic                q_full,
    output crc16x_pkg::in_item_t push_item
);

    logic in_message_reg;
    logic in_message_next;
    logic accept;

    assign s_ready   = !q_full;
    assign accept    = s_valid && s_ready;
    assign push_item = s_data;

    always_comb begin
        push_hs.valid = accept && (s_data.first_byte || in_message_reg);
        push_hs.ready = s_ready;
    end

    always_comb begin
        in_message_next = in_message_reg;
        if (accept) begin
            if (s_data.first_byte) begin
                in_message_next = !s_data.last_byte;
            end else if (in_message_reg && s_data.last_byte) begin
                in_message_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_message_reg <= 1'b0;
        end else begin
            in_message_reg <= in_message_next;
        end
    end

endmodule

// ===== rtl/crc16x_queue.sv =====
// Short FIFO of classified items between the front end and the CRC engine.
// Depends on crc16x_pkg.
module crc16x_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  crc16x_pkg::in_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output crc16x_pkg::in_item_t pop_item
);

    crc16x_pkg::in_item_t              mem_reg [crc16x_pkg::QUEUE_DEPTH];
    logic [crc16x_pkg::QUEUE_AW-1:0]   wr_ptr_reg;
    logic [crc16x_pkg::QUEUE_AW-1:0]   wr_ptr_next;
    logic [crc16x_pkg::QUEUE_AW-1:0]   rd_ptr_reg;
    logic [crc16x_pkg::QUEUE_AW-1:0]   rd_ptr_next;
    logic [crc16x_pkg::QUEUE_CW-1:0]   count_reg;
    logic [crc16x_pkg::QUEUE_CW-1:0]   count_next;
    logic                              do_push;
    logic                              do_pop;

    assign full      = (count_reg == crc16x_pkg::QUEUE_CW'(crc16x_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == crc16x_pkg::QUEUE_AW'(crc16x_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == crc16x_pkg::QUEUE_AW'(crc16x_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/crc16x_back.sv =====
// Back end: CRC engine, two-byte hold-back for check mode and result register.
// Depends on crc16x_pkg.
module crc16x_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_not_empty,
    input  crc16x_pkg::in_item_t  q_item,
    output logic                  q_pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output crc16x_pkg::out_item_t m_data
);

    logic [15:0]           crc_reg,   crc_next;
    logic [7:0]            held0_reg, held0_next;
    logic [7:0]            held1_reg, held1_next;
    logic [1:0]            count_reg, count_next;
    logic                  checking_reg, checking_next;
    logic                  m_valid_reg, m_valid_next;
    crc16x_pkg::out_item_t result_reg, result_next;

    logic [15:0] crc_base;
    logic [7:0]  held0_base;
    logic [7:0]  held1_base;
    logic [1:0]  count_base;
    logic [15:0] crc_inv;

    assign q_pop   = q_not_empty && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_data  = result_reg;

    always_comb begin
        crc_base      = q_item.first_byte ? crc16x_pkg::CRC_PRESET : crc_reg;
        held0_base    = q_item.first_byte ? 8'h00 : held0_reg;
        held1_base    = q_item.first_byte ? 8'h00 : held1_reg;
        count_base    = q_item.first_byte ? 2'd0 : count_reg;
        checking_next = q_item.first_byte ? q_item.check_mode : checking_reg;

        crc_next   = crc_base;
        held0_next = held0_base;
        held1_next = held1_base;
        count_next = count_base;
        if (checking_next) begin
            if (count_base < 2'd2) begin
                if (count_base[0]) begin
                    held1_next = q_item.data_byte;
                end else begin
                    held0_next = q_item.data_byte;
                end
                count_next = count_base + 2'd1;
            end else begin
                crc_next   = crc16x_pkg::crc_feed(crc_base, held0_base);
                held0_next = held1_base;
                held1_next = q_item.data_byte;
            end
        end else begin
            crc_next = crc16x_pkg::crc_feed(crc_base, q_item.data_byte);
        end

        crc_inv               = ~crc_next;
        result_next.crc_value = crc_inv;
        if (!checking_next) begin
            result_next.crc_ok    = 1'b1;
            result_next.too_short = 1'b0;
        end else if (count_next < 2'd2) begin
            result_next.crc_ok    = 1'b0;
            result_next.too_short = 1'b1;
        end else begin
            result_next.crc_ok    = ({held0_next, held1_next} == crc_inv);
            result_next.too_short = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (q_pop && q_item.last_byte) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && q_item.last_byte) begin
            result_reg <= result_next;
        end
        if (q_pop) begin
            held0_reg <= held0_next;
            held1_reg <= held1_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg      <= crc16x_pkg::CRC_PRESET;
            count_reg    <= 2'd0;
            checking_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (q_pop) begin
                crc_reg      <= crc_next;
                count_reg    <= count_next;
                checking_reg <= checking_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== rtl/crc16_x25_generate_check_top.sv =====
// CRC-16/X.25 generate/check block: top level joining front end, queue and CRC engine.
// A last byte's result is written to the result register, with m_valid, when the byte leaves the queue.
// Throughput: one byte per cycle while the queue is not full; the byte-wide CRC update sets it.
// A 4-entry queue absorbs output stalls; input stalls only when it is full.
// Reset (aresetn low, synchronous) empties the queue and closes any open message.
// Depends on crc16x_pkg, crc16x_front, crc16x_queue, crc16x_back.
module crc16_x25_generate_check_top (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  crc16x_pkg::in_item_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output crc16x_pkg::out_item_t m_data
);

    crc16x_pkg::q_hs_t    push_hs;
    crc16x_pkg::in_item_t push_item;
    crc16x_pkg::in_item_t pop_item;
    logic                 q_full;
    logic                 q_not_empty;
    logic                 q_pop;

    crc16x_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .push_hs   (push_hs),
        .q_full    (q_full),
        .push_item (push_item)
    );

    crc16x_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push_hs.valid && push_hs.ready),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_item  (pop_item)
    );

    crc16x_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_item      (pop_item),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for crc16_x25_generate_check_top: generate, check, short and stray items.
// Predicts each result with a bitwise CRC-16/X.25 model kept in a scoreboard class.
// Depends on crc16x_pkg for the item types and on the block itself.
module tb_top;

    typedef logic [7:0] byte_q_t[$];

    localparam int unsigned RANDOM_ITEMS = 1950;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned HOLD_CYCLES  = 150;

    class crc_scoreboard;
        localparam logic [15:0] PRESET = 16'hFFFF;
        localparam logic [15:0] POLY   = 16'h8408;

        logic [15:0]           crc_q;
        logic [7:0]            held[2];
        logic [1:0]            held_cnt;
        bit                    checking;
        bit                    msg_open;
        crc16x_pkg::out_item_t crc_due[$];
        bit                    due_gen[$];
        int unsigned           fail_count;
        int unsigned           bytes_seen;
        int unsigned           gen_results;
        int unsigned           chk_good;
        int unsigned           chk_bad;
        int unsigned           chk_short;

        function new();
            crc_q    = PRESET;
            held[0]  = '0;
            held[1]  = '0;
            held_cnt = '0;
            checking = 1'b0;
            msg_open = 1'b0;
        endfunction

        static function logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
            logic [15:0] c;
            bit          fb;
            c = crc;
            for (int i = 0; i < 8; i++) begin
                fb = c[0] ^ b[i];
                c  = c >> 1;
                if (fb) begin
                    c = c ^ POLY;
                end
            end
            return c;
        endfunction

        function void note_byte(crc16x_pkg::in_item_t it);
            crc16x_pkg::out_item_t res;
            bytes_seen++;
            if (it.first_byte) begin
                crc_q    = PRESET;
                held[0]  = '0;
                held[1]  = '0;
                held_cnt = '0;
                checking = it.check_mode;
                msg_open = 1'b1;
            end else if (!msg_open) begin
                return;
            end
            if (checking) begin
                if (held_cnt < 2) begin
                    held[held_cnt] = it.data_byte;
                    held_cnt++;
                end else begin
                    crc_q   = crc_step(crc_q, held[0]);
                    held[0] = held[1];
                    held[1] = it.data_byte;
                end
            end else begin
                crc_q = crc_step(crc_q, it.data_byte);
            end
            if (!it.last_byte) begin
                return;
            end
            msg_open      = 1'b0;
            res.crc_value = ~crc_q;
            if (!checking) begin
                res.crc_ok    = 1'b1;
                res.too_short = 1'b0;
            end else if (held_cnt < 2) begin
                res.crc_ok    = 1'b0;
                res.too_short = 1'b1;
            end else begin
                res.crc_ok    = ({held[0], held[1]} == res.crc_value);
                res.too_short = 1'b0;
            end
            crc_due.push_back(res);
            due_gen.push_back(!checking);
        endfunction

        function void check_result(crc16x_pkg::out_item_t got);
            crc16x_pkg::out_item_t want;
            bit                    gen;
            if (crc_due.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("%0t: unexpected result crc_value=%h crc_ok=%0d too_short=%0d",
                             $time, got.crc_value, got.crc_ok, got.too_short);
                end
                return;
            end
            want = crc_due.pop_front();
            gen  = due_gen.pop_front();
            if (want.too_short) begin
                chk_short++;
            end else if (gen) begin
                gen_results++;
            end else if (want.crc_ok) begin
                chk_good++;
            end else begin
                chk_bad++;
            end
            if (got.crc_value !== want.crc_value || got.crc_ok !== want.crc_ok ||
                got.too_short !== want.too_short) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("%0t: mismatch crc_value exp=%h got=%h crc_ok exp=%0d got=%0d",
                             $time, want.crc_value, got.crc_value, want.crc_ok, got.crc_ok);
                    $display("    too_short exp=%0d got=%0d", want.too_short, got.too_short);
                end
            end
        endfunction
    endclass

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    crc16x_pkg::in_item_t  s_data  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    crc16x_pkg::out_item_t m_data;

    int unsigned tx_idle_pct = 26;
    int unsigned rx_idle_pct = 72;
    int unsigned cycle_cnt   = 0;
    bit          tb_msg_open = 1'b0;

    crc_scoreboard sb = new();

    crc16_x25_generate_check_top u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_byte(s_data);
            end
            if (m_valid && m_ready) begin
                sb.check_result(m_data);
            end
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            cycle_cnt++;
            if (cycle_cnt > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycle_cnt);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // hold off the receiver now and then so the block backs up into its input
    initial begin
        int unsigned rx_cycle;
        int unsigned hold_left;
        rx_cycle  = 0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            rx_cycle++;
            if (rx_cycle == 600 || rx_cycle == 3500) begin
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic send_byte(input crc16x_pkg::in_item_t it);
        int unsigned gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < tx_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
    endtask

    task automatic send_message(input bit mode, input byte_q_t bytes, input bit closed);
        crc16x_pkg::in_item_t it;
        foreach (bytes[i]) begin
            it.data_byte  = bytes[i];
            it.first_byte = (i == 0);
            it.last_byte  = closed && (i == bytes.size() - 1);
            it.check_mode = (i == 0) ? mode : 1'($urandom_range(1));
            send_byte(it);
        end
        tb_msg_open = !closed;
    endtask

    task automatic send_stray();
        crc16x_pkg::in_item_t it;
        it.data_byte  = 8'($urandom_range(255));
        it.first_byte = 1'b0;
        it.last_byte  = 1'($urandom_range(1));
        it.check_mode = 1'($urandom_range(1));
        send_byte(it);
    endtask

    function automatic byte_q_t random_bytes(input int unsigned n);
        byte_q_t q;
        repeat (n) q.push_back(8'($urandom_range(255)));
        return q;
    endfunction

    // append the inverted CRC high byte first; optionally spoil one bit of it
    function automatic byte_q_t with_crc(input byte_q_t body, input bit spoil);
        byte_q_t     q;
        logic [15:0] crc;
        logic [15:0] fcs;
        q   = body;
        crc = 16'hFFFF;
        foreach (body[i]) begin
            crc = crc_scoreboard::crc_step(crc, body[i]);
        end
        fcs = ~crc;
        if (spoil) begin
            fcs[$urandom_range(15)] ^= 1'b1;
        end
        q.push_back(fcs[15:8]);
        q.push_back(fcs[7:0]);
        return q;
    endfunction

    initial begin
        int unsigned sent;
        int unsigned kind;
        int unsigned n;
        int unsigned errors;
        bit          mode;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_stray();
        send_message(1'b0, '{8'h00}, 1'b1);
        send_message(1'b0, '{8'hFF}, 1'b1);
        send_message(1'b1, '{8'hA5}, 1'b1);
        send_message(1'b1, '{8'h00, 8'h00}, 1'b1);
        send_message(1'b1, '{8'h12, 8'h34}, 1'b1);
        send_message(1'b0, '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39},
                     1'b1);
        send_message(1'b0, '{8'hC3, 8'h3C}, 1'b0);
        send_message(1'b1, with_crc('{8'h7E}, 1'b0), 1'b1);
        send_stray();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent >= 2 * RANDOM_ITEMS / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else if (sent >= RANDOM_ITEMS / 3) begin
                tx_idle_pct = 72;
                rx_idle_pct = 26;
            end
            kind = $urandom_range(99);
            mode = 1'($urandom_range(1));
            n    = ($urandom_range(9) < 7) ? $urandom_range(7) : $urandom_range(40, 8);
            if (kind < 8 && !tb_msg_open) begin
                repeat ($urandom_range(3, 1)) send_stray();
            end else if (kind < 18) begin
                send_message(mode, random_bytes($urandom_range(6, 1)), 1'b0);
                sent += 1;
            end else if (mode && $urandom_range(19) == 0) begin
                send_message(1'b1, random_bytes(1), 1'b1);
                sent += 1;
            end else if (mode) begin
                send_message(1'b1, with_crc(random_bytes(n), $urandom_range(99) < 25), 1'b1);
                sent += n + 2;
            end else begin
                send_message(1'b0, random_bytes(n + 1), 1'b1);
                sent += n + 1;
            end
        end
        s_valid <= 1'b0;

        while (sb.crc_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (10) @(posedge aclk);

        errors = sb.fail_count + sb.crc_due.size();
        if (sb.crc_due.size() != 0) begin
            $display("%0d expected results never arrived", sb.crc_due.size());
        end
        $display("covered %0d bytes in %0d cycles with sender and receiver stalls",
                 sb.bytes_seen, cycle_cnt);
        $display("and two long holds; results: %0d generate, %0d check good, %0d check bad, %0d too short",
                 sb.gen_results, sb.chk_good, sb.chk_bad, sb.chk_short);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
